// ----- rtl/crc64bt_pkg.sv -----
// Shared types and the 256-entry checksum ROM for the byte-wise CRC-64 block.
package crc64bt_pkg;

    localparam int CRC_WIDTH  = 64;
    localparam int BYTE_WIDTH = 8;
    localparam int ROM_DEPTH  = 1 << BYTE_WIDTH;

    // One input beat as held in the input register
    typedef struct packed {
        logic [BYTE_WIDTH-1:0] data;
        logic                  first;
        logic                  last;
    } beat_t;

    // Fixed lookup table, used as listed
    localparam logic [CRC_WIDTH-1:0] CRC_ROM [ROM_DEPTH] = '{
        64'h0000000000000000, 64'h0809e8a2969451e9, 64'h1013d1452d28a3d2, 64'h181a39e7bbbcf23b,
        64'h2027a28a5a5147a4, 64'h282e4a28ccc5164d, 64'h303473cf7779e476, 64'h383d9b6de1edb59f,
        64'h404f4514b4a28f48, 64'h4846adb62236dea1, 64'h505c9451998a2c9a, 64'h58557cf30f1e7d73,
        64'h6068e79eeef3c8ec, 64'h68610f3c78679905, 64'h707b36dbc3db6b3e, 64'h7872de79554f3ad7,
        64'h809e8a2969451e90, 64'h8897628bffd14f79, 64'h908d5b6c446dbd42, 64'h9884b3ced2f9ecab,
        64'ha0b928a333145934, 64'ha8b0c001a58008dd, 64'hb0aaf9e61e3cfae6, 64'hb8a3114488a8ab0f,
        64'hc0d1cf3ddde791d8, 64'hc8d8279f4b73c031, 64'hd0c21e78f0cf320a, 64'hd8cbf6da665b63e3,
        64'he0f66db787b6d67c, 64'he8ff851511228795, 64'hf0e5bcf2aa9e75ae, 64'hf8ec54503c0a2447,
        64'h24b1909974c84e69, 64'h2cb8783be25c1f80, 64'h34a241dc59e0edbb, 64'h3caba97ecf74bc52,
        64'h049632132e9909cd, 64'h0c9fdab1b80d5824, 64'h1485e35603b1aa1f, 64'h1c8c0bf49525fbf6,
        64'h64fed58dc06ac121, 64'h6cf73d2f56fe90c8, 64'h74ed04c8ed4262f3, 64'h7ce4ec6a7bd6331a,
        64'h44d977079a3b8685, 64'h4cd09fa50cafd76c, 64'h54caa642b7132557, 64'h5cc34ee0218774be,
        64'ha42f1ab01d8d50f9, 64'hac26f2128b190110, 64'hb43ccbf530a5f32b, 64'hbc352357a631a2c2,
        64'h8408b83a47dc175d, 64'h8c015098d14846b4, 64'h941b697f6af4b48f, 64'h9c1281ddfc60e566,
        64'he4605fa4a92fdfb1, 64'hec69b7063fbb8e58, 64'hf4738ee184077c63, 64'hfc7a664312932d8a,
        64'hc447fd2ef37e9815, 64'hcc4e158c65eac9fc, 64'hd4542c6bde563bc7, 64'hdc5dc4c948c26a2e,
        64'h49632132e9909cd2, 64'h416ac9907f04cd3b, 64'h5970f077c4b83f00, 64'h517918d5522c6ee9,
        64'h694483b8b3c1db76, 64'h614d6b1a25558a9f, 64'h795752fd9ee978a4, 64'h715eba5f087d294d,
        64'h092c64265d32139a, 64'h01258c84cba64273, 64'h193fb563701ab048, 64'h11365dc1e68ee1a1,
        64'h290bc6ac0763543e, 64'h21022e0e91f705d7, 64'h391817e92a4bf7ec, 64'h3111ff4bbcdfa605,
        64'hc9fdab1b80d58242, 64'hc1f443b91641d3ab, 64'hd9ee7a5eadfd2190, 64'hd1e792fc3b697079,
        64'he9da0991da84c5e6, 64'he1d3e1334c10940f, 64'hf9c9d8d4f7ac6634, 64'hf1c03076613837dd,
        64'h89b2ee0f34770d0a, 64'h81bb06ada2e35ce3, 64'h99a13f4a195faed8, 64'h91a8d7e88fcbff31,
        64'ha9954c856e264aae, 64'ha19ca427f8b21b47, 64'hb9869dc0430ee97c, 64'hb18f7562d59ab895,
        64'h6dd2b1ab9d58d2bb, 64'h65db59090bcc8352, 64'h7dc160eeb0707169, 64'h75c8884c26e42080,
        64'h4df51321c709951f, 64'h45fcfb83519dc4f6, 64'h5de6c264ea2136cd, 64'h55ef2ac67cb56724,
        64'h2d9df4bf29fa5df3, 64'h25941c1dbf6e0c1a, 64'h3d8e25fa04d2fe21, 64'h3587cd589246afc8,
        64'h0dba563573ab1a57, 64'h05b3be97e53f4bbe, 64'h1da987705e83b985, 64'h15a06fd2c817e86c,
        64'hed4c3b82f41dcc2b, 64'he545d32062899dc2, 64'hfd5feac7d9356ff9, 64'hf55602654fa13e10,
        64'hcd6b9908ae4c8b8f, 64'hc56271aa38d8da66, 64'hdd78484d8364285d, 64'hd571a0ef15f079b4,
        64'had037e9640bf4363, 64'ha50a9634d62b128a, 64'hbd10afd36d97e0b1, 64'hb5194771fb03b158,
        64'h8d24dc1c1aee04c7, 64'h852d34be8c7a552e, 64'h9d370d5937c6a715, 64'h953ee5fba152f6fc,
        64'h92c64265d32139a4, 64'h9acfaac745b5684d, 64'h82d59320fe099a76, 64'h8adc7b82689dcb9f,
        64'hb2e1e0ef89707e00, 64'hbae8084d1fe42fe9, 64'ha2f231aaa458ddd2, 64'haafbd90832cc8c3b,
        64'hd28907716783b6ec, 64'hda80efd3f117e705, 64'hc29ad6344aab153e, 64'hca933e96dc3f44d7,
        64'hf2aea5fb3dd2f148, 64'hfaa74d59ab46a0a1, 64'he2bd74be10fa529a, 64'heab49c1c866e0373,
        64'h1258c84cba642734, 64'h1a5120ee2cf076dd, 64'h024b1909974c84e6, 64'h0a42f1ab01d8d50f,
        64'h327f6ac6e0356090, 64'h3a76826476a13179, 64'h226cbb83cd1dc342, 64'h2a6553215b8992ab,
        64'h52178d580ec6a87c, 64'h5a1e65fa9852f995, 64'h42045c1d23ee0bae, 64'h4a0db4bfb57a5a47,
        64'h72302fd25497efd8, 64'h7a39c770c203be31, 64'h6223fe9779bf4c0a, 64'h6a2a1635ef2b1de3,
        64'hb677d2fca7e977cd, 64'hbe7e3a5e317d2624, 64'ha66403b98ac1d41f, 64'hae6deb1b1c5585f6,
        64'h96507076fdb83069, 64'h9e5998d46b2c6180, 64'h8643a133d09093bb, 64'h8e4a49914604c252,
        64'hf63897e8134bf885, 64'hfe317f4a85dfa96c, 64'he62b46ad3e635b57, 64'hee22ae0fa8f70abe,
        64'hd61f3562491abf21, 64'hde16ddc0df8eeec8, 64'hc60ce42764321cf3, 64'hce050c85f2a64d1a,
        64'h36e958d5ceac695d, 64'h3ee0b077583838b4, 64'h26fa8990e384ca8f, 64'h2ef3613275109b66,
        64'h16cefa5f94fd2ef9, 64'h1ec712fd02697f10, 64'h06dd2b1ab9d58d2b, 64'h0ed4c3b82f41dcc2,
        64'h76a61dc17a0ee615, 64'h7eaff563ec9ab7fc, 64'h66b5cc84572645c7, 64'h6ebc2426c1b2142e,
        64'h5681bf4b205fa1b1, 64'h5e8857e9b6cbf058, 64'h46926e0e0d770263, 64'h4e9b86ac9be3538a,
        64'hdba563573ab1a576, 64'hd3ac8bf5ac25f49f, 64'hcbb6b212179906a4, 64'hc3bf5ab0810d574d,
        64'hfb82c1dd60e0e2d2, 64'hf38b297ff674b33b, 64'heb9110984dc84100, 64'he398f83adb5c10e9,
        64'h9bea26438e132a3e, 64'h93e3cee118877bd7, 64'h8bf9f706a33b89ec, 64'h83f01fa435afd805,
        64'hbbcd84c9d4426d9a, 64'hb3c46c6b42d63c73, 64'habde558cf96ace48, 64'ha3d7bd2e6ffe9fa1,
        64'h5b3be97e53f4bbe6, 64'h533201dcc560ea0f, 64'h4b28383b7edc1834, 64'h4321d099e84849dd,
        64'h7b1c4bf409a5fc42, 64'h7315a3569f31adab, 64'h6b0f9ab1248d5f90, 64'h63067213b2190e79,
        64'h1b74ac6ae75634ae, 64'h137d44c871c26547, 64'h0b677d2fca7e977c, 64'h036e958d5ceac695,
        64'h3b530ee0bd07730a, 64'h335ae6422b9322e3, 64'h2b40dfa5902fd0d8, 64'h2349370706bb8131,
        64'hff14f3ce4e79eb1f, 64'hf71d1b6cd8edbaf6, 64'hef07228b635148cd, 64'he70eca29f5c51924,
        64'hdf3351441428acbb, 64'hd73ab9e682bcfd52, 64'hcf20800139000f69, 64'hc72968a3af945e80,
        64'hbf5bb6dafadb6457, 64'hb7525e786c4f35be, 64'haf48679fd7f3c785, 64'ha7418f3d4167966c,
        64'h9f7c1450a08a23f3, 64'h9775fcf2361e721a, 64'h8f6fc5158da28021, 64'h87662db71b36d1c8,
        64'h7f8a79e7273cf58f, 64'h77839145b1a8a466, 64'h6f99a8a20a14565d, 64'h679040009c8007b4,
        64'h5faddb6d7d6db22b, 64'h57a433cfebf9e3c2, 64'h4fbe0a28504511f9, 64'h47b7e28ac6d14010,
        64'h3fc53cf3939e7ac7, 64'h37ccd451050a2b2e, 64'h2fd6edb6beb6d915, 64'h27df0514282288fc,
        64'h1fe29e79c9cf3d63, 64'h17eb76db5f5b6c8a, 64'h0ff14f3ce4e79eb1, 64'h07f8a79e7273cf58
    };

endpackage

// ----- rtl/crc64bt_in_stage.sv -----
// Input register stage: captures one byte beat and holds it until the update stage takes it.
module crc64bt_in_stage
    import crc64bt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [BYTE_WIDTH-1:0] data_byte,
    input  logic                  first_byte,
    input  logic                  last_byte,
    output logic                  beat_valid,
    input  logic                  beat_take,
    output beat_t                 beat
);

    logic  valid_reg;
    logic  valid_next;
    beat_t beat_reg;
    logic  load;

    // Accept when empty or when the held beat moves on this cycle
    assign in_ready = !valid_reg || beat_take;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (beat_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on accept
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            beat_reg <= '{data: data_byte, first: first_byte, last: last_byte};
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

// ----- rtl/crc64bt_update.sv -----
// Checksum update stage: one ROM lookup and XOR per beat into the running and result registers.
module crc64bt_update
    import crc64bt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CRC_WIDTH-1:0] cfg_wr_data,
    input  logic                 beat_valid,
    output logic                 beat_take,
    input  beat_t                beat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CRC_WIDTH-1:0] crc_value,
    output logic                 final_res
);

    logic [CRC_WIDTH-1:0]  init_reg;
    logic [CRC_WIDTH-1:0]  running_reg;
    logic [CRC_WIDTH-1:0]  running_next;
    logic [CRC_WIDTH-1:0]  crc_base;
    logic [BYTE_WIDTH-1:0] sel;
    logic                  valid_reg;
    logic                  valid_next;
    logic [CRC_WIDTH-1:0]  crc_reg;
    logic                  final_reg;
    logic                  room;

    // Result register has room when empty or being drained
    assign room      = !valid_reg || out_ready;
    assign beat_take = beat_valid && room;

    // Reload on a first byte, then one table step
    always_comb
    begin
        crc_base     = beat.first ? init_reg : running_reg;
        sel          = crc_base[BYTE_WIDTH-1:0] ^ beat.data;
        running_next = CRC_ROM[sel] ^ (crc_base >> BYTE_WIDTH);
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (beat_take)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg    <= '0;
            running_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                init_reg <= cfg_wr_data;
            end
            if (beat_take)
            begin
                running_reg <= running_next;
            end
            valid_reg <= valid_next;
        end
    end

    // Hold result payload until drained
    always_ff @(posedge clk)
    begin
        if (beat_take)
        begin
            crc_reg   <= running_next;
            final_reg <= beat.last;
        end
    end

    assign out_valid = valid_reg;
    assign crc_value = crc_reg;
    assign final_res = final_reg;

endmodule

// ----- rtl/crc64_bytewise_table.sv -----
// Top level of the byte-wise table-driven CRC-64 block.
//
// Usage:
//   Input channel in_valid/in_ready carries one byte beat: data_byte plus
//   first_byte (reload the checksum from init_value before this byte) and
//   last_byte (echoed on final_res). Output channel out_valid/out_ready
//   carries the running checksum after each byte on crc_value.
//   cfg_wr_en/cfg_wr_data write init_value; write it only while idle.
// Timing:
//   Every accepted byte gives exactly one result. An accepted byte sits
//   in the input register, then moves into the result register, where it
//   can be taken. Throughput is one byte per cycle while out_ready stays
//   high, set by the running-checksum register loop through the
//   256-entry ROM and one XOR.
// Reset:
//   rst_n clears init_value and the running checksum to zero and empties
//   both stages.
// Stall:
//   While out_ready is low the result holds; one more byte is taken into
//   the input register, after which in_ready drops until the result drains.
module crc64_bytewise_table
    import crc64bt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CRC_WIDTH-1:0]  cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [BYTE_WIDTH-1:0] data_byte,
    input  logic                  first_byte,
    input  logic                  last_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [CRC_WIDTH-1:0]  crc_value,
    output logic                  final_res
);

    logic  beat_valid;
    logic  beat_take;
    beat_t beat;

    // Register incoming beat
    crc64bt_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .beat_valid (beat_valid),
        .beat_take  (beat_take),
        .beat       (beat)
    );

    // Advance the checksum and register the result
    crc64bt_update u_update (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .beat_valid  (beat_valid),
        .beat_take   (beat_take),
        .beat        (beat),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .crc_value   (crc_value),
        .final_res   (final_res)
    );

endmodule

// ----- rtl/crc64bt_checker.sv -----
// Port-level assertions for the CRC-64 block, bound to the top level.
module crc64bt_checker
    import crc64bt_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [CRC_WIDTH-1:0]  crc_value,
    input logic                  final_res
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(crc_value) && $stable(final_res))
        else $error("result beat changed while stalled");

    // Input stalls only behind a full result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty output");

    // Empty output always leaves room for a beat
    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input not ready with empty output");

    // An accepted beat reaches the output past the input register when not blocked
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready |=> out_valid)
        else $error("accepted beat did not reach the output");

endmodule

bind crc64_bytewise_table crc64bt_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .crc_value (crc_value),
    .final_res (final_res)
);

// ----- sim/crc64bt_checker.sv -----
// Checker for the byte-wise CRC-64 block: predicts each running checksum and compares it.
module crc64bt_scoreboard
    import crc64bt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CRC_WIDTH-1:0]  cfg_wr_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [BYTE_WIDTH-1:0] data_byte,
    input  logic                  first_byte,
    input  logic                  last_byte,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [CRC_WIDTH-1:0]  crc_value,
    input  logic                  final_res,
    output int                    sums_waiting,
    output int                    mismatches
);

    typedef struct packed {
        logic [CRC_WIDTH-1:0] crc;
        logic                 fin;
    } crc_sum_t;

    crc_sum_t             expected_sums[$];
    logic [CRC_WIDTH-1:0] seed_value;
    logic [CRC_WIDTH-1:0] chain_crc;
    int                   fail_tally;

    // Fold one byte into the checksum through the lookup table
    function automatic logic [CRC_WIDTH-1:0] crc_advance(
        input logic [CRC_WIDTH-1:0]  prev,
        input logic [BYTE_WIDTH-1:0] data
    );
        logic [BYTE_WIDTH-1:0] sel;
        sel = prev[BYTE_WIDTH-1:0] ^ data;
        return CRC_ROM[sel] ^ (prev >> BYTE_WIDTH);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        crc_sum_t             head;
        logic [CRC_WIDTH-1:0] base;
        if (!rst_n)
        begin
            expected_sums.delete();
            seed_value = '0;
            chain_crc  = '0;
            fail_tally = 0;
        end
        else
        begin
            // Track the init value register
            if (cfg_wr_en)
                seed_value = cfg_wr_data;

            // Predict the checksum for each accepted input beat
            if (in_valid && in_ready)
            begin
                base      = first_byte ? seed_value : chain_crc;
                chain_crc = crc_advance(base, data_byte);
                expected_sums.push_back('{crc: chain_crc, fin: last_byte});
            end

            // Compare each accepted output beat with the oldest prediction
            if (out_valid && out_ready)
            begin
                if (expected_sums.size() == 0)
                begin
                    $display("%0t: unexpected result beat: crc_value %h final_res %b",
                             $time, crc_value, final_res);
                    fail_tally++;
                end
                else
                begin
                    head = expected_sums.pop_front();
                    if (crc_value !== head.crc)
                    begin
                        $display("%0t: crc_value mismatch: expected %h, actual %h",
                                 $time, head.crc, crc_value);
                        fail_tally++;
                    end
                    if (final_res !== head.fin)
                    begin
                        $display("%0t: final_res mismatch: expected %b, actual %b",
                                 $time, head.fin, final_res);
                        fail_tally++;
                    end
                end
            end
        end
        sums_waiting <= expected_sums.size();
        mismatches   <= fail_tally;
    end

endmodule

// ----- sim/tb_crc64_bytewise_table.sv -----
// Testbench top for the byte-wise CRC-64 block: stimulus, receiver stalls and verdict.
module tb_crc64_bytewise_table
    import crc64bt_pkg::*;
();

    localparam int RANDOM_ITEMS   = 1900;
    localparam int PHASE_ITEMS    = 240;
    localparam int HOLDOFF_CYCLES = 250;
    localparam int CYCLE_LIMIT    = 600000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CRC_WIDTH-1:0]  cfg_wr_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [BYTE_WIDTH-1:0] data_byte;
    logic                  first_byte;
    logic                  last_byte;
    logic                  out_valid;
    logic                  out_ready;
    logic [CRC_WIDTH-1:0]  crc_value;
    logic                  final_res;
    int                    sums_waiting;
    int                    mismatches;
    int                    results_taken = 0;

    crc64_bytewise_table dut (.*);

    crc64bt_scoreboard u_scoreboard (.*);

    // Free-running clock, period 2
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Count delivered result beats to time the long receiver hold-off
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            results_taken <= results_taken + 1;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r = $urandom_range(99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(2, 1);
        if (r < 97)
            return $urandom_range(8, 3);
        return $urandom_range(50, 20);
    endfunction

    function automatic logic [CRC_WIDTH-1:0] pick_seed();
        int r = $urandom_range(5);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    // Offer one input beat and hold it until accepted
    task automatic send_byte(input logic [BYTE_WIDTH-1:0] d, input logic f, input logic l);
        @(negedge clk);
        in_valid   <= 1'b1;
        data_byte  <= d;
        first_byte <= f;
        last_byte  <= l;
        do @(posedge clk); while (!in_ready);
    endtask

    // Drop valid for the given number of cycles
    task automatic idle_in(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    // Wait until every predicted checksum has come back
    task automatic drain();
        idle_in(1);
        do @(posedge clk); while (sums_waiting != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_seed(input logic [CRC_WIDTH-1:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Send one well-formed buffer with random bytes
    task automatic send_buffer(input int len, input bit burst);
        for (int i = 0; i < len; i++)
        begin
            send_byte(BYTE_WIDTH'($urandom_range(255)), i == 0, i == len - 1);
            if (!burst)
                idle_in(pick_gap());
        end
    endtask

    // Receiver: random stalls, full-speed stretches and a long hold-off now and then
    initial
    begin : receiver
        int hold_at;
        int stall;
        out_ready = 1'b0;
        hold_at   = 500;
        @(posedge rst_n);
        forever
        begin
            if (results_taken >= hold_at)
            begin
                // Hold off long enough that the block fills and stalls its input
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES - 1) @(negedge clk);
                hold_at += 700;
            end
            @(negedge clk);
            out_ready <= 1'b1;
            if ($urandom_range(99) < 20)
            begin
                repeat ($urandom_range(80, 30) - 1) @(negedge clk);
            end
            else
            begin
                repeat ($urandom_range(12, 1) - 1) @(negedge clk);
                stall = pick_gap();
                if (stall > 0)
                begin
                    @(negedge clk);
                    out_ready <= 1'b0;
                    repeat (stall - 1) @(negedge clk);
                end
            end
        end
    end

    // Sender and verdict
    initial
    begin : stimulus
        int sent;
        int phase_end;
        int len;
        int noise;
        in_valid    = 1'b0;
        data_byte   = '0;
        first_byte  = 1'b0;
        last_byte   = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        rst_n       = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // No start flag yet: chain from the reset value, then past a last byte
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hff, 1'b0, 1'b0);
        send_byte(8'ha5, 1'b0, 1'b1);
        send_byte(8'h3c, 1'b0, 1'b0);
        // One-byte buffer
        send_byte(8'hff, 1'b1, 1'b1);
        drain();

        // All-ones init value
        write_seed('1);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(8'h7f, 1'b0, 1'b1);
        send_byte(8'h00, 1'b1, 1'b1);
        // Open a buffer, then change init value in the middle of it
        send_byte(8'h55, 1'b1, 1'b0);
        drain();
        write_seed(64'h0123456789abcdef);
        send_byte(8'haa, 1'b0, 1'b0);
        send_byte(8'h12, 1'b1, 1'b0);
        send_byte(8'hed, 1'b0, 1'b1);
        drain();

        // Zero init value written explicitly
        write_seed('0);
        send_byte(8'hff, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);

        // Random phases, each under a fresh init value
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            drain();
            write_seed(pick_seed());
            phase_end = sent + PHASE_ITEMS;
            while (sent < phase_end && sent < RANDOM_ITEMS)
            begin
                if ($urandom_range(99) < 85)
                begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(64, 17)
                                                   : $urandom_range(16, 1);
                    send_buffer(len, $urandom_range(4) == 0);
                    sent += len;
                end
                else
                begin
                    // Stray beats with arbitrary flags
                    noise = $urandom_range(6, 1);
                    repeat (noise)
                    begin
                        send_byte(BYTE_WIDTH'($urandom_range(255)), 1'($urandom_range(1)),
                                  1'($urandom_range(1)));
                        idle_in(pick_gap());
                    end
                    sent += noise;
                end
            end
        end

        // Let the last results drain, then decide
        idle_in(1);
        do @(posedge clk); while (sums_waiting != 0);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Stop a hung run
    initial
    begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("== FAIL ==");
        $finish;
    end

endmodule
